>>> rtl/core/plint_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
package plint_pkg;

    // Input item kinds carried on s_tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Field widths fixed by the item format
    localparam int unsigned COORD_W = 32;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned CFG_W   = 7;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 32;

    // Restoring division: one quotient bit per step over a 64-bit dividend
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned DIV_CNT_W = 6;

    // Control state of the query sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    // Per-cell control: rotate the ring, or write this cell's breakpoint
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

>>> rtl/core/piecewise_linear_interpolator_core.sv
// Top level: breakpoint ring, segment scan, multiply and divide sequencer.
//
// Usage: input items arrive on the s_ channel. s_tuser selects the kind:
// a load writes (x, y) into slot point_index (slots at or beyond MAX_POINTS
// are dropped); a query returns one result on the m_ channel with the
// interpolated y in signed Q16.16 and an out-of-range flag on m_tuser.
// cfg_we/cfg_wdata set the number of breakpoints in use (clamped to
// 2..MAX_POINTS); write it only while the block is idle.
// A query rotates the breakpoint ring once past the comparator, forms the
// segment terms, does the 32x32 multiply, runs the bit-serial restoring
// divider and loads the output register. Out of range and last-point
// queries skip the multiply and divide. One query is worked at a time.
// Results sit in an output register; the next item is accepted while a
// result still waits. If the receiver stalls with a result pending, a
// finished query holds until that result is taken.
// Reset clears the sequencer and the output valid and sets points in use
// to 2; breakpoints are undefined until loaded. No item is taken in reset.
module piecewise_linear_interpolator_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config
    input  logic                                 cfg_we,
    input  logic [plint_pkg::CFG_W-1:0]          cfg_wdata,   // points_in_use
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [5:0] point_index, [37:6] x_value, [69:38] y_value, [71:70] zero
    input  logic [plint_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                 s_tuser,     // [0] cmd
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [plint_pkg::OUT_TDATA_W-1:0]    m_tdata,     // [31:0] y_result
    output logic                                 m_tuser      // [0] out_of_range
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = plint_pkg::COORD_W;

    plint_pkg::state_t state_reg, state_next;

    logic [plint_pkg::CFG_W-1:0] points_in_use_reg;
    logic [NW-1:0]               n_reg;
    logic [NW-1:0]               n_eff;
    logic [IW-1:0]               scan_cnt_reg;
    logic [plint_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic signed [CW-1:0] qx_reg;
    logic signed [CW-1:0] x0_reg, xlast_reg, ylast_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] xl_reg, yl_reg, xr_reg, yr_reg;
    logic                 found_reg;

    logic [CW-1:0]        dx_reg, t_reg, mag_reg;
    logic                 neg_reg, special_reg;
    logic signed [CW-1:0] special_val_reg;
    logic                 outside_reg;
    logic [63:0]          quo_reg;
    logic [CW-1:0]        rem_reg;

    logic                 m_tvalid_reg, m_tuser_reg;
    logic [CW-1:0]        m_tdata_reg;

    logic [5:0]           in_idx;
    logic signed [CW-1:0] in_x, in_y;
    logic                 in_fire, load_fire;

    logic signed [CW-1:0] ring_x [MAX_POINTS];
    logic signed [CW-1:0] ring_y [MAX_POINTS];
    logic                 ring_shift;

    assign in_idx = s_tdata[5:0];
    assign in_x   = s_tdata[37:6];
    assign in_y   = s_tdata[69:38];

    assign s_tready  = aresetn && (state_reg == plint_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == plint_pkg::CMD_LOAD);
    assign ring_shift = (state_reg == plint_pkg::ST_SCAN);

    // Breakpoint ring: cell i takes from cell i+1 on rotate
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        plint_pkg::cell_ctrl_t ctrl;
        assign ctrl.shift = ring_shift;
        assign ctrl.load  = load_fire && (int'(in_idx) == i);
        plint_cell u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .load_x (in_x),
            .load_y (in_y),
            .next_x (ring_x[(i + 1) % MAX_POINTS]),
            .next_y (ring_y[(i + 1) % MAX_POINTS]),
            .x_out  (ring_x[i]),
            .y_out  (ring_y[i])
        );
    end

    // Clamp the configured count into 2..MAX_POINTS
    always_comb begin
        if (points_in_use_reg < 7'd2) begin
            n_eff = NW'(2);
        end else if (int'(points_in_use_reg) > MAX_POINTS) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = NW'(points_in_use_reg);
        end
    end

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_in_use_reg <= 7'd2;
        end else if (cfg_we) begin
            points_in_use_reg <= cfg_wdata;
        end
    end

    // Segment terms from the located breakpoints
    logic              cur_gt;
    logic              scan_in_use, scan_is_last, scan_done;
    logic signed [CW:0] dy_w;
    logic              outside_w, eq_last_w;
    logic signed [CW+1:0] sum_w;
    logic [CW-1:0]     trial_sub;
    logic [CW:0]       trial;
    logic              trial_ge;

    assign cur_gt       = ring_x[0] > qx_reg;
    assign scan_in_use  = (scan_cnt_reg != '0) && (NW'(scan_cnt_reg) < n_reg);
    assign scan_is_last = (NW'(scan_cnt_reg) == n_reg - 1'b1);
    assign scan_done    = (scan_cnt_reg == IW'(MAX_POINTS - 1));

    assign dy_w      = {yr_reg[CW-1], yr_reg} - {yl_reg[CW-1], yl_reg};
    assign outside_w = (qx_reg < x0_reg) || (qx_reg > xlast_reg);
    assign eq_last_w = (qx_reg == xlast_reg);

    assign trial     = {rem_reg, quo_reg[63]};
    assign trial_ge  = trial >= {1'b0, dx_reg};
    assign trial_sub = CW'(trial - {1'b0, dx_reg});

    assign sum_w = neg_reg
        ? ({{2{yl_reg[CW-1]}}, yl_reg} - $signed({2'b00, quo_reg[CW-1:0]}))
        : ({{2{yl_reg[CW-1]}}, yl_reg} + $signed({2'b00, quo_reg[CW-1:0]}));

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= plint_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plint_pkg::ST_IDLE: begin
                if (in_fire && (s_tuser == plint_pkg::CMD_QUERY)) begin
                    state_next = plint_pkg::ST_SCAN;
                end
            end
            plint_pkg::ST_SCAN: begin
                if (scan_done) state_next = plint_pkg::ST_EVAL;
            end
            plint_pkg::ST_EVAL: begin
                if (outside_w || eq_last_w || (xr_reg == xl_reg)) begin
                    state_next = plint_pkg::ST_FIN;
                end else begin
                    state_next = plint_pkg::ST_MUL;
                end
            end
            plint_pkg::ST_MUL: state_next = plint_pkg::ST_DIV;
            plint_pkg::ST_DIV: begin
                if (div_cnt_reg == plint_pkg::DIV_CNT_W'(plint_pkg::DIV_STEPS - 1)) begin
                    state_next = plint_pkg::ST_FIN;
                end
            end
            plint_pkg::ST_FIN: begin
                if (!m_tvalid_reg || m_tready) state_next = plint_pkg::ST_IDLE;
            end
            default: state_next = plint_pkg::ST_IDLE;
        endcase
    end

    // Scan counter and segment search flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
        end else if (state_reg == plint_pkg::ST_SCAN) begin
            scan_cnt_reg <= scan_done ? '0 : scan_cnt_reg + 1'b1;
            if ((scan_in_use && cur_gt) || scan_is_last) found_reg <= 1'b1;
        end else if (state_reg == plint_pkg::ST_IDLE) begin
            found_reg <= 1'b0;
        end
    end

    // Capture query and breakpoints as the ring goes by
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            qx_reg <= in_x;
            n_reg  <= n_eff;
        end
        if (state_reg == plint_pkg::ST_SCAN) begin
            prev_x_reg <= ring_x[0];
            prev_y_reg <= ring_y[0];
            if (scan_cnt_reg == '0) x0_reg <= ring_x[0];
            if (scan_is_last) begin
                xlast_reg <= ring_x[0];
                ylast_reg <= ring_y[0];
            end
            if (!found_reg && ((scan_in_use && cur_gt) || scan_is_last)) begin
                xl_reg <= prev_x_reg;
                yl_reg <= prev_y_reg;
                xr_reg <= ring_x[0];
                yr_reg <= ring_y[0];
            end
        end
    end

    // Segment terms, multiply and bit-serial divide
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (state_reg == plint_pkg::ST_DIV) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end else begin
            div_cnt_reg <= '0;
        end
        unique case (state_reg)
            plint_pkg::ST_EVAL: begin
                outside_reg <= outside_w;
                special_reg <= outside_w || eq_last_w || (xr_reg == xl_reg);
                if (outside_w) begin
                    special_val_reg <= '0;
                end else if (eq_last_w) begin
                    special_val_reg <= ylast_reg;
                end else begin
                    special_val_reg <= yl_reg;
                end
                dx_reg  <= CW'(xr_reg - xl_reg);
                t_reg   <= CW'(qx_reg - xl_reg);
                neg_reg <= dy_w[CW];
                mag_reg <= dy_w[CW] ? CW'(-dy_w) : CW'(dy_w);
            end
            plint_pkg::ST_MUL: begin
                quo_reg <= t_reg * mag_reg;
                rem_reg <= '0;
            end
            plint_pkg::ST_DIV: begin
                quo_reg <= {quo_reg[62:0], trial_ge};
                rem_reg <= trial_ge ? trial_sub : trial[CW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Output register: load on finish, drop valid on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == plint_pkg::ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (state_reg == plint_pkg::ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tuser_reg <= outside_reg;
            if (special_reg) begin
                m_tdata_reg <= special_val_reg;
            end else if (sum_w > 34'sh07FFFFFFF) begin
                m_tdata_reg <= 32'h7FFFFFFF;
            end else if (sum_w < -34'sh080000000) begin
                m_tdata_reg <= 32'h80000000;
            end else begin
                m_tdata_reg <= sum_w[CW-1:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Scan counter rests at zero outside the scan
    a_scan_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != plint_pkg::ST_SCAN) |-> (scan_cnt_reg == '0))
        else $error("scan counter not at zero outside scan");

    // Every finished scan has located a segment
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == plint_pkg::ST_EVAL) |-> found_reg)
        else $error("scan ended without a segment");

    // Divider partial remainder stays below the divisor
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == plint_pkg::ST_DIV) |-> (rem_reg < dx_reg))
        else $error("divider remainder out of bounds");

endmodule

>>> rtl/core/plint_cell.sv
// One breakpoint cell of the rotating table ring.
module plint_cell (
    input  logic                                aclk,
    input  plint_pkg::cell_ctrl_t               ctrl,
    input  logic signed [plint_pkg::COORD_W-1:0] load_x,
    input  logic signed [plint_pkg::COORD_W-1:0] load_y,
    input  logic signed [plint_pkg::COORD_W-1:0] next_x,
    input  logic signed [plint_pkg::COORD_W-1:0] next_y,
    output logic signed [plint_pkg::COORD_W-1:0] x_out,
    output logic signed [plint_pkg::COORD_W-1:0] y_out
);

    logic signed [plint_pkg::COORD_W-1:0] x_reg;
    logic signed [plint_pkg::COORD_W-1:0] y_reg;

    // Take the neighbor's point on rotate, else the loaded point
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            x_reg <= next_x;
            y_reg <= next_y;
        end else if (ctrl.load) begin
            x_reg <= load_x;
            y_reg <= load_y;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

>>> tb/piecewise_linear_interpolator_core_test.sv
// Self-checking testbench for the piecewise linear interpolator core.
`timescale 1ns / 100ps

module piecewise_linear_interpolator_core_test;

    localparam int NPTS      = 64;
    localparam int DRAIN_CYC = NPTS + 100;
    localparam int WD_LIMIT  = 4000;
    localparam longint XMIN  = -64'sd2147483648;
    localparam longint XMAX  = 64'sd2147483647;

    typedef struct {
        logic [31:0] y_result;
        logic        out_of_range;
    } interp_result_t;

    // Tracks the breakpoint table and the queue of expected query results
    class interp_scoreboard;
        longint         bp_x[NPTS];
        longint         bp_y[NPTS];
        int             pts_used = 2;
        interp_result_t expected_q[$];
        int             errors = 0;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_points(int v);
            pts_used = v;
        endfunction

        function interp_result_t interpolate(logic [31:0] xq);
            interp_result_t res;
            int n, k;
            longint x, xl, yl, dy, r;
            bit [63:0] dx, t, q, mag;
            n = pts_used < 2 ? 2 : (pts_used > NPTS ? NPTS : pts_used);
            x = longint'($signed(xq));
            res.out_of_range = 1'b0;
            res.y_result = '0;
            if (x < bp_x[0] || x > bp_x[n-1]) begin
                res.out_of_range = 1'b1;
                return res;
            end
            if (x == bp_x[n-1]) begin
                res.y_result = bp_y[n-1][31:0];
                return res;
            end
            k = n - 1;
            for (int i = 1; i < n; i++) begin
                if (bp_x[i] > x) begin
                    k = i;
                    break;
                end
            end
            xl = bp_x[k-1];
            yl = bp_y[k-1];
            dx = bp_x[k] - xl;
            t  = x - xl;
            dy = bp_y[k] - yl;
            if (dx == 0) begin
                res.y_result = yl[31:0];
                return res;
            end
            mag = dy < 0 ? -dy : dy;
            q = (mag * t) / dx;
            if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
            r = dy < 0 ? yl - longint'(q) : yl + longint'(q);
            if (r > XMAX) r = XMAX;
            if (r < XMIN) r = XMIN;
            res.y_result = r[31:0];
            return res;
        endfunction

        // Note an accepted input transfer
        function void note_input(logic cmd, logic [5:0] idx, logic [31:0] x, logic [31:0] y);
            if (cmd == plint_pkg::CMD_LOAD) begin
                bp_x[idx] = longint'($signed(x));
                bp_y[idx] = longint'($signed(y));
            end else begin
                expected_q = {expected_q, interpolate(x)};
            end
        endfunction

        // Compare one accepted result against the oldest expectation
        task check(logic [31:0] y_res, logic oor);
            interp_result_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result y=%h oor=%b", y_res, oor));
                return;
            end
            e = expected_q.pop_front();
            if (y_res !== e.y_result)
                report($sformatf("y_result got %h exp %h", y_res, e.y_result));
            if (oor !== e.out_of_range)
                report($sformatf("out_of_range got %b exp %b", oor, e.out_of_range));
        endtask
    endclass

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [plint_pkg::CFG_W-1:0]       cfg_wdata = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [plint_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                              s_tuser = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [plint_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              m_tuser;

    interp_scoreboard sb = new();
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     pts_active = 2;
    longint tab_x[NPTS];
    int     quiet_cycles = 0;

    piecewise_linear_interpolator_core #(.MAX_POINTS(NPTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("piecewise_linear_interpolator_core_test failed");
            $finish;
        end
    end

    // Present one item and hold it until the transfer
    task automatic send_item(logic cmd, logic [5:0] idx, longint x, longint y);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, y[31:0], x[31:0], idx};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, idx, x[31:0], y[31:0]);
    endtask

    task automatic load_point(int idx, longint x, longint y);
        tab_x[idx] = x;
        send_item(plint_pkg::CMD_LOAD, idx[5:0], x, y);
    endtask

    task automatic query(longint x);
        send_item(plint_pkg::CMD_QUERY, 6'd0, x, 0);
    endtask

    // Drain all results and let the sequencer settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic write_points(int v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[plint_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_points(v);
        pts_active = v < 2 ? 2 : (v > NPTS ? NPTS : v);
    endtask

    // Load slots 0..cnt-1: wide spans the full x range, narrow uses small steps,
    // scrambled drops the ordering
    task automatic load_table(int kind, int cnt);
        longint x;
        x = (kind == 0) ? XMIN : longint'($signed($urandom)) / 2;
        for (int i = 0; i < cnt; i++) begin
            if (kind == 2)
                x = longint'($signed($urandom));
            else if (i > 0)
                x = x + 1 + (kind == 0 ? $urandom_range(32'h03FF_FFFE) : $urandom_range(4095));
            if (kind == 0 && i == cnt - 1) x = XMAX;
            load_point(i, x, longint'($signed($urandom)));
        end
    endtask

    // One query chosen to hit a segment, a breakpoint, the ends or random x
    task automatic random_query();
        int n, sel, j;
        longint lo, hi, x;
        n   = pts_active;
        sel = $urandom_range(99);
        lo  = tab_x[0];
        hi  = tab_x[n-1];
        j   = $urandom_range(n - 2);
        if (sel < 55 && tab_x[j+1] > tab_x[j])
            x = tab_x[j] + longint'($urandom) % (tab_x[j+1] - tab_x[j]);
        else if (sel < 65)
            x = tab_x[j];
        else if (sel < 72)
            x = hi;
        else if (sel < 80 && lo > XMIN)
            x = lo - 1 - longint'($urandom) % (lo - XMIN);
        else if (sel < 88 && hi < XMAX)
            x = hi + 1 + longint'($urandom) % (XMAX - hi);
        else
            x = longint'($signed($urandom));
        query(x);
    endtask

    initial begin
        int cfg_list[8];
        int idle_send[4];
        int idle_recv[4];

        cfg_list  = '{64, 2, 127, 0, 1, 0, 0, 64};
        idle_send = '{0, 67, 0, 33};
        idle_recv = '{0, 0, 67, 33};
        cfg_list[5] = $urandom_range(3, 63);
        cfg_list[6] = $urandom_range(3, 63);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every slot so no query ever reads an unloaded entry
        load_table(0, NPTS);

        // Directed: extreme endpoints with two points in use
        load_point(0, XMIN, XMIN);
        load_point(1, XMAX, XMAX);
        query(XMIN);
        query(XMAX);
        query(0);
        query(-1);
        query(XMAX - 1);
        load_point(1, XMAX, XMIN);
        query(0);
        query(XMIN + 1);
        load_point(0, -65536, 32'sh7FFF_0000);
        load_point(1, 65536, -32'sh7FFF_0000);
        query(XMIN);
        query(XMAX);
        query(-65536);
        query(65536);
        query(1);
        query(-1);

        // Random phases with varied idling and table sizes
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            for (int t = 0; t < 2; t++) begin
                write_points(cfg_list[p*2 + t]);
                load_table((t == 1 && p == 3) ? 2 : $urandom_range(1), pts_active);
                for (int q = 0; q < 28; q++) begin
                    if ($urandom_range(19) == 0) begin
                        // rewrite one slot keeping order when possible
                        int j;
                        j = $urandom_range(pts_active - 1);
                        load_point(j, tab_x[j], longint'($signed($urandom)));
                    end
                    random_query();
                end
            end
        end

        wait_idle();
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0)
            $display("piecewise_linear_interpolator_core_test passed");
        else
            $display("piecewise_linear_interpolator_core_test failed");
        $finish;
    end

endmodule
